@@ rtl/bms_response_frame_receiver_defines.svh @@
// Assertion macros for the poll response frame receiver.
// Used by the port checker; depends on nothing.
`ifndef BMS_RESPONSE_FRAME_RECEIVER_DEFINES_SVH
`define BMS_RESPONSE_FRAME_RECEIVER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define BRFR_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("brfr assertion failed");

// Next-cycle implication, checked outside reset.
`define BRFR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("brfr assertion failed");

`endif

@@ rtl/brfr_pkg.sv @@
// Shared types, constants and the CRC-16 byte update for the frame receiver.
// No dependencies.
`default_nettype none

package brfr_pkg;

  typedef enum logic [1:0] {
    MODE_ARM  = 2'd0,
    MODE_BYTE = 2'd1,
    MODE_TICK = 2'd2
  } mode_e;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_BAD_CRC = 3'd1,
    ST_BAD_LEN = 3'd2,
    ST_BAD_CMD = 3'd3,
    ST_TIMEOUT = 3'd4
  } status_e;

  localparam logic REG_TIMEOUT = 1'b0;
  localparam logic REG_CMD     = 1'b1;

  localparam logic [7:0]  START_MARK  = 8'h7a;
  localparam logic [7:0]  END_MARK    = 8'ha7;
  localparam logic [15:0] CRC_INIT    = 16'hffff;
  localparam logic [15:0] CRC_POLY    = 16'ha001;
  localparam logic [9:0]  MIN_FRAME   = 10'd8;
  localparam logic [15:0] TIMEOUT_RST = 16'd500;
  localparam logic [15:0] CMD_RST     = 16'h0001;

  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] data);
    logic [15:0] c;
    c = crc ^ {8'h00, data};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

@@ rtl/bms_response_frame_receiver.sv @@
// Accepted transfers enter the input register; results are registered at the output.
// Throughput: one item per cycle, the byte state update and CRC step being one stage;
// a waiting result holds only an item that has a result, others still pass through.
// Reset: disarmed, frame state cleared, timeout 500 ms, expected command 1.
// Poll response frame receiver top level; depends on brfr_pkg.
`default_nettype none

module bms_response_frame_receiver (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_index_i,
  input  wire logic [15:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  mode_i,
  input  wire logic [7:0]  rx_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [2:0]       status_o,
  output logic [15:0]      command_o,
  output logic [7:0]       payload_length_o
);

  logic [15:0] timeout_q;
  logic [15:0] exp_cmd_q;

  logic        in_valid_q;
  logic [1:0]  mode_q;
  logic [7:0]  byte_q;

  logic        armed_q, armed_d;
  logic [8:0]  byte_cnt_q, byte_cnt_d;
  logic [7:0]  frame_len_q, frame_len_d;
  logic [15:0] crc_run_q, crc_run_d;
  logic [15:0] crc_rcv_q, crc_rcv_d;
  logic [15:0] cmd_q, cmd_d;
  logic        end_missed_q, end_missed_d;
  logic [15:0] elapsed_q, elapsed_d;

  logic        out_valid_q;
  logic [2:0]  status_q;
  logic [15:0] command_q;
  logic [7:0]  len_q;

  logic        res_valid;
  brfr_pkg::status_e res_status;
  logic [15:0] res_cmd;
  logic [7:0]  res_len;

  logic [9:0]  pos;
  logic [7:0]  len_w;
  logic [9:0]  len_x;
  logic [9:0]  total;
  logic [9:0]  need;
  logic        fold, shift, end_bad;
  logic        out_free, proc_fire;

  assign pos     = {1'b0, byte_cnt_q};
  assign len_w   = (byte_cnt_q == 9'd2) ? byte_q : frame_len_q;
  assign len_x   = {2'b00, len_w};
  assign total   = pos + 10'd1;
  assign need    = ((len_x + 10'd4) < brfr_pkg::MIN_FRAME) ? brfr_pkg::MIN_FRAME
                                                           : (len_x + 10'd4);
  assign fold    = (pos >= 10'd2) && (pos <= len_x + 10'd1);
  assign shift   = (pos <= len_x + 10'd2);
  assign end_bad = (pos >= 10'd3) && (pos == len_x + 10'd3) && (byte_q != brfr_pkg::END_MARK);

  always_comb begin
    armed_d      = armed_q;
    byte_cnt_d   = byte_cnt_q;
    frame_len_d  = frame_len_q;
    crc_run_d    = crc_run_q;
    crc_rcv_d    = crc_rcv_q;
    cmd_d        = cmd_q;
    end_missed_d = end_missed_q;
    elapsed_d    = elapsed_q;
    res_valid    = 1'b0;
    res_status   = brfr_pkg::ST_OK;
    res_cmd      = 16'h0000;
    res_len      = 8'h00;
    if (in_valid_q) begin
      case (mode_q)
        brfr_pkg::MODE_ARM: begin
          if (!armed_q) begin
            armed_d      = 1'b1;
            byte_cnt_d   = 9'd0;
            frame_len_d  = 8'h00;
            crc_run_d    = brfr_pkg::CRC_INIT;
            crc_rcv_d    = 16'h0000;
            cmd_d        = 16'h0000;
            end_missed_d = 1'b0;
            elapsed_d    = 16'h0000;
          end
        end
        brfr_pkg::MODE_BYTE: begin
          if (armed_q && !end_missed_q) begin
            if (byte_cnt_q == 9'd0) begin
              if (byte_q == brfr_pkg::START_MARK) begin
                byte_cnt_d = 9'd1;
              end
            end else begin
              if (byte_cnt_q == 9'd2) begin
                frame_len_d = byte_q;
              end
              if (fold) begin
                crc_run_d = brfr_pkg::crc16_byte(crc_run_q, crc_rcv_q[7:0]);
              end
              if (shift) begin
                crc_rcv_d = {crc_rcv_q[7:0], byte_q};
              end
              if (byte_cnt_q == 9'd5) begin
                cmd_d[15:8] = byte_q;
              end
              if (byte_cnt_q == 9'd6) begin
                cmd_d[7:0] = byte_q;
              end
              byte_cnt_d = total[8:0];
              if (end_bad) begin
                end_missed_d = 1'b1;
              end else if (total >= need) begin
                res_valid = 1'b1;
                res_cmd   = cmd_d;
                res_len   = frame_len_d;
                armed_d   = 1'b0;
                if (crc_run_d != crc_rcv_d) begin
                  res_status = brfr_pkg::ST_BAD_CRC;
                end else if (total != len_x + 10'd4) begin
                  res_status = brfr_pkg::ST_BAD_LEN;
                end else if (cmd_d != exp_cmd_q) begin
                  res_status = brfr_pkg::ST_BAD_CMD;
                end else begin
                  res_status = brfr_pkg::ST_OK;
                end
              end
            end
          end
        end
        brfr_pkg::MODE_TICK: begin
          if (armed_q) begin
            if (elapsed_q >= timeout_q) begin
              res_valid  = 1'b1;
              res_status = brfr_pkg::ST_TIMEOUT;
              armed_d    = 1'b0;
            end else begin
              elapsed_d = elapsed_q + 16'd1;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign out_free   = !out_valid_q || out_ready_i;
  assign proc_fire  = in_valid_q && (!res_valid || out_free);
  assign in_ready_o = !in_valid_q || proc_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= brfr_pkg::TIMEOUT_RST;
      exp_cmd_q <= brfr_pkg::CMD_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        brfr_pkg::REG_TIMEOUT: timeout_q <= cfg_data_i;
        brfr_pkg::REG_CMD:     exp_cmd_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      mode_q <= mode_i;
      byte_q <= rx_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q      <= 1'b0;
      byte_cnt_q   <= 9'd0;
      frame_len_q  <= 8'h00;
      crc_run_q    <= brfr_pkg::CRC_INIT;
      crc_rcv_q    <= 16'h0000;
      cmd_q        <= 16'h0000;
      end_missed_q <= 1'b0;
      elapsed_q    <= 16'h0000;
    end else if (proc_fire) begin
      armed_q      <= armed_d;
      byte_cnt_q   <= byte_cnt_d;
      frame_len_q  <= frame_len_d;
      crc_run_q    <= crc_run_d;
      crc_rcv_q    <= crc_rcv_d;
      cmd_q        <= cmd_d;
      end_missed_q <= end_missed_d;
      elapsed_q    <= elapsed_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (proc_fire && res_valid) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc_fire && res_valid) begin
      status_q  <= res_status;
      command_q <= res_cmd;
      len_q     <= res_len;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = status_q;
  assign command_o        = command_q;
  assign payload_length_o = len_q;

endmodule

`default_nettype wire

@@ rtl/brfr_checker.sv @@
// Port-level checks for the frame receiver, bound to the top level.
// Depends on brfr_pkg and bms_response_frame_receiver_defines.svh.
`default_nettype none
`include "bms_response_frame_receiver_defines.svh"

module brfr_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [2:0]  status_o,
  input wire logic [15:0] command_o,
  input wire logic [7:0]  payload_length_o
);

  logic        out_stall;
  logic [26:0] out_word;
  logic        out_timeout;
  logic        out_bad_len;

  assign out_stall   = out_valid_o && !out_ready_i;
  assign out_word    = {status_o, command_o, payload_length_o};
  assign out_timeout = out_valid_o && (status_o == brfr_pkg::ST_TIMEOUT);
  assign out_bad_len = out_valid_o && (status_o == brfr_pkg::ST_BAD_LEN);

  `BRFR_ASSERT_NEXT(a_out_hold, out_stall, out_valid_o && $stable(out_word))
  `BRFR_ASSERT_NOW(a_status_range, out_valid_o, status_o <= brfr_pkg::ST_TIMEOUT)
  `BRFR_ASSERT_NOW(a_timeout_zero, out_timeout, ~|{command_o, payload_length_o})
  `BRFR_ASSERT_NOW(a_bad_len_short, out_bad_len, payload_length_o < 8'd4)

endmodule

bind bms_response_frame_receiver brfr_checker u_brfr_checker (.*);

`default_nettype wire

@@ bench/tb_top.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the poll response frame receiver.
// Predicts each response from its own copy of the receiver state and checks every
// transfer on the result port; depends on brfr_pkg and the receiver RTL.

module tb_top;

  localparam logic [1:0] MODE_RSVD = 2'd3;

  typedef enum int {FLAW_NONE, FLAW_CRC, FLAW_CMD, FLAW_END, FLAW_CUT} flaw_e;

  typedef struct packed {
    brfr_pkg::status_e status;
    logic [15:0]       command;
    logic [7:0]        plen;
  } poll_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic        cfg_index_i = 1'b0;
  logic [15:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  mode_i = '0;
  logic [7:0]  rx_byte_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [2:0]  status_o;
  logic [15:0] command_o;
  logic [7:0]  payload_length_o;

  bms_response_frame_receiver u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .mode_i          (mode_i),
    .rx_byte_i       (rx_byte_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .status_o        (status_o),
    .command_o       (command_o),
    .payload_length_o(payload_length_o)
  );

  always #5 clk_i = ~clk_i;

  // receiver-side copy of the configuration and frame state
  logic [15:0] cfg_timeout = brfr_pkg::TIMEOUT_RST;
  logic [15:0] cfg_cmd = brfr_pkg::CMD_RST;
  bit          rx_armed = 1'b0;
  int          rx_count = 0;
  logic [7:0]  rx_len = '0;
  logic [15:0] rx_crc_acc = brfr_pkg::CRC_INIT;
  logic [15:0] rx_crc_word = '0;
  logic [15:0] rx_cmd_word = '0;
  bit          rx_end_lost = 1'b0;
  logic [15:0] rx_ms = '0;

  poll_result_t pending_responses[$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int stall_hold = 0;
  int fail_count = 0;
  int items_sent = 0;
  int frames_sent = 0;
  int responses_seen = 0;
  int timeouts_seen = 0;

  function automatic logic [15:0] modbus_crc_step(input logic [15:0] acc,
                                                  input logic [7:0] d);
    logic [15:0] r;
    r = acc;
    for (int i = 0; i < 8; i++) begin
      if (r[0] ^ d[i]) r = (r >> 1) ^ brfr_pkg::CRC_POLY;
      else r = r >> 1;
    end
    return r;
  endfunction

  function automatic bit predict_response(input logic [1:0] m, input logic [7:0] b,
                                          output poll_result_t r);
    int p;
    int len;
    int need;
    bit hit;
    hit = 1'b0;
    r = '0;
    case (m)
      brfr_pkg::MODE_ARM: begin
        if (!rx_armed) begin
          rx_armed = 1'b1;
          rx_count = 0;
          rx_len = '0;
          rx_crc_acc = brfr_pkg::CRC_INIT;
          rx_crc_word = '0;
          rx_cmd_word = '0;
          rx_end_lost = 1'b0;
          rx_ms = '0;
        end
      end
      brfr_pkg::MODE_TICK: begin
        if (rx_armed) begin
          if (rx_ms >= cfg_timeout) begin
            rx_armed = 1'b0;
            r.status = brfr_pkg::ST_TIMEOUT;
            hit = 1'b1;
          end else begin
            rx_ms = rx_ms + 16'd1;
          end
        end
      end
      brfr_pkg::MODE_BYTE: begin
        if (rx_armed && !rx_end_lost) begin
          p = rx_count;
          if (p == 0) begin
            if (b == brfr_pkg::START_MARK) rx_count = 1;
          end else begin
            len = (p == 2) ? int'(b) : int'(rx_len);
            if (p == 2) rx_len = b;
            // fold the previous byte once it is known to be payload
            if (p >= 2 && p - 1 <= len) begin
              rx_crc_acc = modbus_crc_step(rx_crc_acc, rx_crc_word[7:0]);
            end
            if (p <= len + 2) rx_crc_word = {rx_crc_word[7:0], b};
            if (p == 5) rx_cmd_word[15:8] = b;
            if (p == 6) rx_cmd_word[7:0] = b;
            if (p >= 3 && p == len + 3 && b != brfr_pkg::END_MARK) begin
              rx_end_lost = 1'b1;
              rx_count = p + 1;
            end else begin
              rx_count = p + 1;
              need = (len + 4 < int'(brfr_pkg::MIN_FRAME)) ? int'(brfr_pkg::MIN_FRAME)
                                                            : len + 4;
              if (p + 1 >= need) begin
                if (rx_crc_acc != rx_crc_word) r.status = brfr_pkg::ST_BAD_CRC;
                else if (p + 1 != len + 4) r.status = brfr_pkg::ST_BAD_LEN;
                else if (rx_cmd_word != cfg_cmd) r.status = brfr_pkg::ST_BAD_CMD;
                else r.status = brfr_pkg::ST_OK;
                r.command = rx_cmd_word;
                r.plen = rx_len;
                rx_armed = 1'b0;
                hit = 1'b1;
              end
            end
          end
        end
      end
      default: ;
    endcase
    return hit;
  endfunction

  always @(posedge clk_i) begin
    if (stall_hold > 0) begin
      out_ready_i <= 1'b0;
      stall_hold <= stall_hold - 1;
    end else begin
      out_ready_i <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    poll_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_responses.size() == 0) begin
        $error("response with none pending: status %0d command %h length %0d",
               status_o, command_o, payload_length_o);
        fail_count++;
      end else begin
        want = pending_responses.pop_front();
        responses_seen++;
        if (want.status == brfr_pkg::ST_TIMEOUT) timeouts_seen++;
        if (status_o !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status_o);
          fail_count++;
        end
        if (command_o !== want.command) begin
          $error("command: expected %h, got %h", want.command, command_o);
          fail_count++;
        end
        if (payload_length_o !== want.plen) begin
          $error("payload_length: expected %0d, got %0d", want.plen, payload_length_o);
          fail_count++;
        end
      end
    end
  end

  task automatic send_item(input logic [1:0] m, input logic [7:0] b);
    poll_result_t res;
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_valid_i <= 1'b1;
    mode_i <= m;
    rx_byte_i <= b;
    do @(posedge clk_i); while (!in_ready_o);
    items_sent++;
    if (predict_response(m, b, res)) pending_responses.push_back(res);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending_responses.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [15:0] val);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    if (idx == brfr_pkg::REG_TIMEOUT) cfg_timeout = val;
    else cfg_cmd = val;
  endtask

  task automatic feed_frame(input int plen, input flaw_e flaw, input int tick_pct);
    logic [7:0]  fb[$];
    logic [15:0] crc;
    int          size;
    int          cut;
    size = (plen + 4 < 8) ? 8 : plen + 4;
    for (int i = 0; i < size; i++) fb.push_back(8'($urandom));
    fb[0] = brfr_pkg::START_MARK;
    fb[2] = 8'(plen);
    if (plen >= 6) begin
      fb[5] = cfg_cmd[15:8];
      fb[6] = cfg_cmd[7:0];
      if (flaw == FLAW_CMD) fb[6] = fb[6] ^ 8'($urandom_range(1, 255));
    end
    crc = brfr_pkg::CRC_INIT;
    for (int i = 1; i <= plen; i++) crc = modbus_crc_step(crc, fb[i]);
    if (plen + 1 >= 3) fb[plen + 1] = crc[15:8];
    if (plen + 2 >= 3) fb[plen + 2] = crc[7:0];
    fb[plen + 3] = brfr_pkg::END_MARK;
    case (flaw)
      FLAW_CRC: if (plen >= 2) fb[plen + 1] = fb[plen + 1] ^ (8'd1 << $urandom_range(0, 7));
      FLAW_END: fb[plen + 3] = brfr_pkg::END_MARK ^ 8'($urandom_range(1, 255));
      FLAW_CUT: begin
        cut = $urandom_range(1, size - 1);
        while (fb.size() > cut) void'(fb.pop_back());
      end
      default: ;
    endcase
    foreach (fb[i]) begin
      if ($urandom_range(0, 99) < tick_pct) send_item(brfr_pkg::MODE_TICK, 8'($urandom));
      send_item(brfr_pkg::MODE_BYTE, fb[i]);
    end
    frames_sent++;
  endtask

  task automatic random_frame();
    int    plen;
    int    pick;
    flaw_e flaw;
    send_item(brfr_pkg::MODE_ARM, 8'($urandom));
    repeat ($urandom_range(0, 2)) begin
      case ($urandom_range(0, 3))
        0: send_item(brfr_pkg::MODE_BYTE, 8'($urandom));
        1: send_item(brfr_pkg::MODE_TICK, 8'($urandom));
        2: send_item(MODE_RSVD, 8'($urandom));
        default: send_item(brfr_pkg::MODE_ARM, 8'($urandom));
      endcase
    end
    pick = $urandom_range(0, 99);
    if (pick < 8) plen = $urandom_range(0, 3);
    else if (pick < 96) plen = $urandom_range(4, 24);
    else plen = $urandom_range(25, 255);
    pick = $urandom_range(0, 99);
    if (pick < 60) flaw = FLAW_NONE;
    else if (pick < 70) flaw = FLAW_CRC;
    else if (pick < 80) flaw = FLAW_CMD;
    else if (pick < 90) flaw = FLAW_END;
    else flaw = FLAW_CUT;
    feed_frame(plen, flaw, 4);
    // drain a stuck reception with ticks
    while (rx_armed) send_item(brfr_pkg::MODE_TICK, 8'($urandom));
  endtask

  task automatic test_unarmed_inputs();
    send_item(brfr_pkg::MODE_TICK, 8'h00);
    send_item(brfr_pkg::MODE_BYTE, 8'hff);
    send_item(MODE_RSVD, brfr_pkg::START_MARK);
  endtask

  task automatic test_padded_frame();
    send_item(brfr_pkg::MODE_ARM, 8'h00);
    send_item(brfr_pkg::MODE_BYTE, 8'h00);
    send_item(brfr_pkg::MODE_ARM, 8'hff);
    feed_frame(2, FLAW_NONE, 0);
  endtask

  task automatic test_zero_timeout();
    wait_idle();
    write_reg(brfr_pkg::REG_TIMEOUT, 16'h0000);
    send_item(brfr_pkg::MODE_ARM, 8'h55);
    send_item(brfr_pkg::MODE_TICK, 8'haa);
  endtask

  task automatic test_missing_end();
    wait_idle();
    write_reg(brfr_pkg::REG_TIMEOUT, 16'd1);
    send_item(brfr_pkg::MODE_ARM, 8'h00);
    feed_frame(0, FLAW_END, 0);
    while (rx_armed) send_item(brfr_pkg::MODE_TICK, 8'hff);
  endtask

  task automatic test_register_extremes();
    wait_idle();
    write_reg(brfr_pkg::REG_TIMEOUT, 16'hffff);
    write_reg(brfr_pkg::REG_CMD, 16'hffff);
    send_item(brfr_pkg::MODE_ARM, 8'h00);
    feed_frame(6, FLAW_NONE, 0);
    wait_idle();
    write_reg(brfr_pkg::REG_CMD, 16'h0000);
    send_item(brfr_pkg::MODE_ARM, 8'h00);
    feed_frame(255, FLAW_NONE, 0);
  endtask

  task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                     input logic [15:0] tmo, input int n_items);
    int start;
    wait_idle();
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    write_reg(brfr_pkg::REG_TIMEOUT, tmo);
    write_reg(brfr_pkg::REG_CMD, 16'($urandom));
    start = items_sent;
    while (items_sent - start < n_items) random_frame();
  endtask

  task automatic test_output_backpressure();
    wait_idle();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    stall_hold = 300;
    repeat (10) begin
      send_item(brfr_pkg::MODE_ARM, 8'($urandom));
      feed_frame($urandom_range(0, 4), FLAW_NONE, 0);
    end
  endtask

  initial begin
    send_idle_pct = 22;
    recv_stall_pct = 59;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_unarmed_inputs();
    test_padded_frame();
    test_zero_timeout();
    test_missing_end();
    test_register_extremes();
    test_random_traffic(22, 59, 16'($urandom_range(8, 40)), 70);
    test_random_traffic(59, 22, 16'd1, 70);
    test_random_traffic(0, 0, 16'($urandom_range(8, 40)), 70);
    test_output_backpressure();
    wait_idle();
    repeat (10) @(posedge clk_i);
    if (pending_responses.size() != 0) begin
      $error("%0d responses never arrived", pending_responses.size());
      fail_count++;
    end
    $display("covered %0d items over %0d frames, including arm, tick, noise and reserved modes",
             items_sent, frames_sent);
    $display("checked %0d responses, %0d of them timeouts", responses_seen, timeouts_seen);
    if (fail_count == 0) begin
      $display("bms_response_frame_receiver regression: pass");
    end else begin
      $display("bms_response_frame_receiver regression: fail");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("bms_response_frame_receiver regression: fail");
    $finish;
  end

endmodule
